>>> rtl/svpwm_pkg.sv
// Shared types, constants and the arctangent table for the space-vector PWM duty block.
package svpwm_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLT_LIMIT = 2'd0,
    CFG_SUPPLY     = 2'd1,
    CFG_PERIOD     = 2'd2
  } cfg_idx_e;

  // Register reset values.
  localparam logic [14:0] VOLT_LIMIT_RESET = 15'd3072;
  localparam logic [14:0] SUPPLY_RESET     = 15'd3072;
  localparam logic [15:0] PERIOD_RESET     = 16'd2099;

  // Input word and result word.
  typedef struct packed {
    logic signed [15:0] volt_q;
    logic signed [15:0] volt_d;
    logic [15:0]        elec_angle;
  } cmd_t;

  typedef struct packed {
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;
    logic [2:0]  raw_sector;
  } res_t;

  // Cycles from an accepted command to its result strobe.
  localparam int LATENCY = 69;

  // Datapath widths.
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam int SQ_RAD_W     = 48;
  localparam int SQ_REM_W     = 26;
  localparam int SQ_ROOT_W    = 24;
  localparam int DIV_NUM_W    = 16;
  localparam int DIV_REM_W    = 15;

  // Fixed-point constants.
  localparam logic [15:0]                MI_MAX_Q16   = 16'd37814;
  localparam logic signed [CORDIC_W-1:0] SQRT3_Q30    = 34'sd1859775394;
  localparam logic signed [CORDIC_W-1:0] INV_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [35:0]         ONE_Q30      = 36'sd1073741824;
  localparam logic [31:0]                QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0]                HALF_TURN    = 32'h8000_0000;
  // Reciprocal of three, exact for any 32-bit dividend after a shift by 33.
  localparam logic [31:0]                RECIP3       = 32'hAAAA_AAAB;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input int step);
    logic [31:0] val;
    case (step)
      0:  val = 32'h2000_0000;
      1:  val = 32'h12E4_051E;
      2:  val = 32'h09FB_385B;
      3:  val = 32'h0511_11D4;
      4:  val = 32'h028B_0D43;
      5:  val = 32'h0145_D7E1;
      6:  val = 32'h00A2_F61E;
      7:  val = 32'h0051_7C55;
      8:  val = 32'h0028_BE53;
      9:  val = 32'h0014_5F2F;
      10: val = 32'h000A_2F98;
      11: val = 32'h0005_17CC;
      12: val = 32'h0002_8BE6;
      13: val = 32'h0001_45F3;
      14: val = 32'h0000_A2FA;
      15: val = 32'h0000_517D;
      16: val = 32'h0000_28BE;
      17: val = 32'h0000_145F;
      18: val = 32'h0000_0A30;
      19: val = 32'h0000_0518;
      20: val = 32'h0000_028C;
      21: val = 32'h0000_0146;
      22: val = 32'h0000_00A3;
      23: val = 32'h0000_0051;
      24: val = 32'h0000_0029;
      25: val = 32'h0000_0014;
      26: val = 32'h0000_000A;
      27: val = 32'h0000_0005;
      28: val = 32'h0000_0003;
      29: val = 32'h0000_0001;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/space_vector_pwm_duty.sv
// Top level of the space-vector PWM duty generator (d/q command to three compare values).
//
// The block takes one command word in every clock cycle and never stalls: busy_o stays low.
// Each result appears on result_o for one cycle with done_o high, in the order the commands
// were accepted. The critical path holds two cell chains, a 30-cell vectoring CORDIC for
// atan2(q, d) and a 30-cell rotation CORDIC for the two sector sines, and the multiply
// stages; the exact square root (24 cells) and the 16-cell divider by the supply voltage
// run alongside. There is no back-pressure, so the receiver must take each result in the
// cycle it is shown. Configuration writes take effect at once and must only be made while
// no command is in flight.
module space_vector_pwm_duty #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  svpwm_pkg::cmd_t                    cmd_i,
  input  logic                               cfg_we_i,
  input  logic [svpwm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [svpwm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                               done_o,
  output svpwm_pkg::res_t                    result_o
);

  localparam int LAT   = svpwm_pkg::LATENCY;
  localparam int CW    = svpwm_pkg::CORDIC_W;
  localparam int NSTEP = svpwm_pkg::CORDIC_STEPS;
  localparam int NSQ   = svpwm_pkg::SQ_ROOT_W;
  localparam int NDIV  = svpwm_pkg::DIV_NUM_W;
  localparam int ASH   = 31 - ANGLE_BITS;

  // Configuration registers.
  logic [14:0] vlim_q;
  logic [14:0] vsup_q;
  logic [15:0] per_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlim_q <= svpwm_pkg::VOLT_LIMIT_RESET;
      vsup_q <= svpwm_pkg::SUPPLY_RESET;
      per_q  <= svpwm_pkg::PERIOD_RESET;
    end else if (cfg_we_i) begin
      case (svpwm_pkg::cfg_idx_e'(cfg_idx_i))
        svpwm_pkg::CFG_VOLT_LIMIT: vlim_q <= cfg_wdata_i[14:0];
        svpwm_pkg::CFG_SUPPLY:     vsup_q <= cfg_wdata_i[14:0];
        svpwm_pkg::CFG_PERIOD:     per_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Valid tokens travel alongside the free-running datapath.
  logic           accept;
  logic [LAT:1]   vld_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-1:1], accept};
    end
  end

  // Sideband delay lines, indexed by the stage whose register they form.
  logic [15:0]  ang_q [1:32];
  logic [2:0]   rs_q  [1:68];
  logic         dnz_q [2:32];
  logic [14:0]  mag_q [2:27];
  logic         neg_q [2:27];
  logic         sat_q [28:44];
  logic         zro_q [28:44];
  logic         ng_q  [28:44];
  logic signed [16:0] u_q [45:65];
  logic [2:0]   sec_q [33:66];

  // ---------------- Stage 1: clamp the voltages, sector of the raw angle ----------------
  function automatic logic signed [15:0] clamp_volt(input logic signed [15:0] v,
                                                    input logic [14:0] lim);
    logic signed [16:0] lim_s;
    logic signed [16:0] v_s;
    logic signed [16:0] r;
    lim_s = $signed({2'b00, lim});
    v_s   = 17'(v);
    if (v_s > lim_s) begin
      r = lim_s;
    end else if (v_s < -lim_s) begin
      r = -lim_s;
    end else begin
      r = v_s;
    end
    return r[15:0];
  endfunction

  logic signed [15:0] q1_q, d1_q;
  logic [18:0]        ang6;

  assign ang6 = 19'(cmd_i.elec_angle) * 19'd6;

  always_ff @(posedge clk_i) begin
    q1_q     <= clamp_volt(cmd_i.volt_q, vlim_q);
    d1_q     <= clamp_volt(cmd_i.volt_d, vlim_q);
    ang_q[1] <= cmd_i.elec_angle;
    rs_q[1]  <= ang6[18:16] + 3'd1;
    for (int k = 2; k <= 32; k++) ang_q[k] <= ang_q[k-1];
    for (int k = 2; k <= 68; k++) rs_q[k] <= rs_q[k-1];
  end

  // ---------------- Stage 2: squares, |q|, CORDIC start vector ----------------
  logic signed [31:0]   dsq, qsq;
  logic [15:0]          qabs;
  logic signed [CW-1:0] vx_init, vy_init;
  logic [29:0]          dd2_q, qq2_q;
  logic signed [CW-1:0] vx [0:NSTEP];
  logic signed [CW-1:0] vy [0:NSTEP];
  logic [31:0]          vz [0:NSTEP];

  always_comb begin
    dsq     = d1_q * d1_q;
    qsq     = q1_q * q1_q;
    qabs    = q1_q[15] ? 16'(-q1_q) : q1_q;
    vx_init = CW'(d1_q) <<< 14;
    vy_init = CW'(q1_q) <<< 14;
  end

  // A negative d is turned by half a turn so the CORDIC starts in the right half-plane.
  always_ff @(posedge clk_i) begin
    dd2_q    <= dsq[29:0];
    qq2_q    <= qsq[29:0];
    dnz_q[2] <= d1_q != 16'sd0;
    mag_q[2] <= qabs[14:0];
    neg_q[2] <= q1_q[15];
    for (int k = 3; k <= 32; k++) dnz_q[k] <= dnz_q[k-1];
    for (int k = 3; k <= 27; k++) begin
      mag_q[k] <= mag_q[k-1];
      neg_q[k] <= neg_q[k-1];
    end
    if (d1_q[15]) begin
      vx[0] <= -vx_init;
      vy[0] <= -vy_init;
      vz[0] <= svpwm_pkg::HALF_TURN;
    end else begin
      vx[0] <= vx_init;
      vy[0] <= vy_init;
      vz[0] <= '0;
    end
  end

  // Vectoring CORDIC chain, stages 3 to 32.
  for (genvar i = 0; i < NSTEP; i++) begin : g_vec
    svpwm_vec_cell #(.STEP(i)) u_cell (
      .clk_i (clk_i),
      .x_i   (vx[i]),
      .y_i   (vy[i]),
      .z_i   (vz[i]),
      .x_o   (vx[i+1]),
      .y_o   (vy[i+1]),
      .z_o   (vz[i+1])
    );
  end

  // ---------------- Stage 3: radicand; square root chain, stages 4 to 27 ----------------
  logic [svpwm_pkg::SQ_RAD_W-1:0]  sq_rad  [0:NSQ];
  logic [svpwm_pkg::SQ_REM_W-1:0]  sq_rem  [0:NSQ];
  logic [svpwm_pkg::SQ_ROOT_W-1:0] sq_root [0:NSQ];

  always_ff @(posedge clk_i) begin
    sq_rad[0] <= {1'b0, 31'(dd2_q) + 31'(qq2_q), 16'h0000};
  end

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    svpwm_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rad_i  (sq_rad[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .rad_o  (sq_rad[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1])
    );
  end

  // ---------------- Stage 28: dividend and saturation check ----------------
  logic [31:0] num_c;
  logic [31:0] num28_q;

  assign num_c = dnz_q[27] ? {sq_root[NSQ], 8'h00} : {1'b0, mag_q[27], 16'h0000};

  // A quotient of 2^16 or more, or a zero supply, saturates the index.
  always_ff @(posedge clk_i) begin
    num28_q   <= num_c;
    zro_q[28] <= num_c == 32'd0;
    sat_q[28] <= (num_c[31:16] >= {1'b0, vsup_q}) && (num_c != 32'd0);
    ng_q[28]  <= !dnz_q[27] && neg_q[27];
    for (int k = 29; k <= 44; k++) begin
      sat_q[k] <= sat_q[k-1];
      zro_q[k] <= zro_q[k-1];
      ng_q[k]  <= ng_q[k-1];
    end
  end

  // Divider chain, stages 29 to 44.
  logic [svpwm_pkg::DIV_REM_W-1:0] dv_rem [0:NDIV];
  logic [svpwm_pkg::DIV_NUM_W-1:0] dv_num [0:NDIV];
  logic [svpwm_pkg::DIV_NUM_W-1:0] dv_quo [0:NDIV];

  assign dv_rem[0] = num28_q[30:16];
  assign dv_num[0] = num28_q[15:0];
  assign dv_quo[0] = '0;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    svpwm_div_cell u_cell (
      .clk_i     (clk_i),
      .divisor_i (vsup_q),
      .rem_i     (dv_rem[k]),
      .num_i     (dv_num[k]),
      .quo_i     (dv_quo[k]),
      .rem_o     (dv_rem[k+1]),
      .num_o     (dv_num[k+1]),
      .quo_o     (dv_quo[k+1])
    );
  end

  // ---------------- Stage 45: clamped, signed modulation index ----------------
  logic [15:0] umag;

  always_comb begin
    if (zro_q[44]) begin
      umag = '0;
    end else if (sat_q[44] || (dv_quo[NDIV] > svpwm_pkg::MI_MAX_Q16)) begin
      umag = svpwm_pkg::MI_MAX_Q16;
    end else begin
      umag = dv_quo[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    u_q[45] <= ng_q[44] ? -$signed({1'b0, umag}) : $signed({1'b0, umag});
    for (int k = 46; k <= 65; k++) u_q[k] <= u_q[k-1];
  end

  // ---------------- Stage 33: shifted angle, sector, in-sector remainder ----------------
  logic [31:0]             th32;
  logic [ANGLE_BITS-1:0]   theta;
  logic [ANGLE_BITS+2:0]   six;
  logic [ANGLE_BITS-1:0]   rem_ang;
  logic [ANGLE_BITS:0]     comp_ang;
  logic [31:0]             n1_q, n2_q;

  always_comb begin
    th32     = {ang_q[32], 16'h0000} + (dnz_q[32] ? vz[NSTEP] : svpwm_pkg::QUARTER_TURN);
    theta    = th32[31 -: ANGLE_BITS];
    six      = (ANGLE_BITS+3)'(theta) * (ANGLE_BITS+3)'(6);
    rem_ang  = six[ANGLE_BITS-1:0];
    comp_ang = {1'b1, {ANGLE_BITS{1'b0}}} - {1'b0, rem_ang};
  end

  // Three times each angle in 2^-32 turn; the divide by three follows.
  always_ff @(posedge clk_i) begin
    sec_q[33] <= six[ANGLE_BITS+2:ANGLE_BITS];
    n1_q      <= 32'(comp_ang) << ASH;
    n2_q      <= 32'(rem_ang) << ASH;
    for (int k = 34; k <= 66; k++) sec_q[k] <= sec_q[k-1];
  end

  // ---------------- Stage 34: divide by three through the reciprocal ----------------
  logic [63:0] pr1, pr2;
  logic [29:0] a1_q, a2_q;

  assign pr1 = 64'(n1_q) * 64'(svpwm_pkg::RECIP3);
  assign pr2 = 64'(n2_q) * 64'(svpwm_pkg::RECIP3);

  always_ff @(posedge clk_i) begin
    a1_q <= pr1[62:33];
    a2_q <= pr2[62:33];
  end

  // Rotation CORDIC chains for both sines, stages 35 to 64.
  logic signed [CW-1:0] r1x [0:NSTEP];
  logic signed [CW-1:0] r1y [0:NSTEP];
  logic signed [CW-1:0] r1z [0:NSTEP];
  logic signed [CW-1:0] r2x [0:NSTEP];
  logic signed [CW-1:0] r2y [0:NSTEP];
  logic signed [CW-1:0] r2z [0:NSTEP];

  assign r1x[0] = svpwm_pkg::INV_GAIN_Q30;
  assign r1y[0] = '0;
  assign r1z[0] = $signed({4'b0000, a1_q});
  assign r2x[0] = svpwm_pkg::INV_GAIN_Q30;
  assign r2y[0] = '0;
  assign r2z[0] = $signed({4'b0000, a2_q});

  for (genvar i = 0; i < NSTEP; i++) begin : g_rot
    svpwm_rot_cell #(.STEP(i)) u_cell1 (
      .clk_i (clk_i),
      .x_i   (r1x[i]),
      .y_i   (r1y[i]),
      .z_i   (r1z[i]),
      .x_o   (r1x[i+1]),
      .y_o   (r1y[i+1]),
      .z_o   (r1z[i+1])
    );
    svpwm_rot_cell #(.STEP(i)) u_cell2 (
      .clk_i (clk_i),
      .x_i   (r2x[i]),
      .y_i   (r2y[i]),
      .z_i   (r2z[i]),
      .x_o   (r2x[i+1]),
      .y_o   (r2y[i+1]),
      .z_o   (r2z[i+1])
    );
  end

  // ---------------- Stage 65: sine times sqrt(3) ----------------
  logic signed [2*CW-1:0] pm1, pm2;
  logic signed [CW-1:0]   p1_q, p2_q;

  assign pm1 = r1y[NSTEP] * svpwm_pkg::SQRT3_Q30;
  assign pm2 = r2y[NSTEP] * svpwm_pkg::SQRT3_Q30;

  always_ff @(posedge clk_i) begin
    p1_q <= pm1[CW+29:30];
    p2_q <= pm2[CW+29:30];
  end

  // ---------------- Stage 66: scale by the modulation index ----------------
  logic signed [CW+16:0] tm1, tm2;
  logic signed [CW-1:0]  t1_q, t2_q;

  assign tm1 = p1_q * u_q[65];
  assign tm2 = p2_q * u_q[65];

  always_ff @(posedge clk_i) begin
    t1_q <= tm1[CW+15:16];
    t2_q <= tm2[CW+15:16];
  end

  // ---------------- Stage 67: zero-vector time and phase on-times ----------------
  logic signed [35:0] t1e, t2e, t12, t0, hz;
  logic signed [35:0] ta_q, tb_q, tc_q;

  always_comb begin
    t1e = 36'(t1_q);
    t2e = 36'(t2_q);
    t12 = t1e + t2e;
    t0  = svpwm_pkg::ONE_Q30 - t12;
    hz  = t0 >>> 1;
  end

  always_ff @(posedge clk_i) begin
    case (sec_q[66])
      3'd0: begin ta_q <= t12 + hz; tb_q <= t2e + hz; tc_q <= hz; end
      3'd1: begin ta_q <= t1e + hz; tb_q <= t12 + hz; tc_q <= hz; end
      3'd2: begin ta_q <= hz; tb_q <= t12 + hz; tc_q <= t2e + hz; end
      3'd3: begin ta_q <= hz; tb_q <= t1e + hz; tc_q <= t12 + hz; end
      3'd4: begin ta_q <= t2e + hz; tb_q <= hz; tc_q <= t12 + hz; end
      default: begin ta_q <= t12 + hz; tb_q <= hz; tc_q <= t1e + hz; end
    endcase
  end

  // ---------------- Stage 68: times the PWM period ----------------
  logic signed [16:0] per_s;
  logic signed [52:0] cma, cmb, cmc;
  logic signed [22:0] ca_q, cb_q, cc_q;

  always_comb begin
    per_s = $signed({1'b0, per_q});
    cma   = ta_q * per_s;
    cmb   = tb_q * per_s;
    cmc   = tc_q * per_s;
  end

  always_ff @(posedge clk_i) begin
    ca_q <= cma[52:30];
    cb_q <= cmb[52:30];
    cc_q <= cmc[52:30];
  end

  // ---------------- Stage 69: saturate and present the result word ----------------
  function automatic logic [15:0] sat_cmp(input logic signed [22:0] c, input logic [15:0] per);
    logic [15:0] r;
    if (c[22]) begin
      r = '0;
    end else if (c > $signed({7'd0, per})) begin
      r = per;
    end else begin
      r = c[15:0];
    end
    return r;
  endfunction

  svpwm_pkg::res_t res_q;

  always_ff @(posedge clk_i) begin
    res_q.compare_a  <= sat_cmp(ca_q, per_q);
    res_q.compare_b  <= sat_cmp(cb_q, per_q);
    res_q.compare_c  <= sat_cmp(cc_q, per_q);
    res_q.raw_sector <= rs_q[68];
  end

  assign result_o = res_q;
  assign done_o   = vld_q[LAT];

endmodule

>>> rtl/svpwm_vec_cell.sv
// One step of the vectoring CORDIC that measures the angle of the (d, q) vector.
module svpwm_vec_cell #(
  parameter int STEP = 0
) (
  input  logic                                    clk_i,
  input  logic signed [svpwm_pkg::CORDIC_W-1:0]   x_i,
  input  logic signed [svpwm_pkg::CORDIC_W-1:0]   y_i,
  input  logic [31:0]                             z_i,
  output logic signed [svpwm_pkg::CORDIC_W-1:0]   x_o,
  output logic signed [svpwm_pkg::CORDIC_W-1:0]   y_o,
  output logic [31:0]                             z_o
);

  localparam logic [31:0] ATAN = svpwm_pkg::atan_turn(STEP);

  // Drive y toward zero; the angle accumulates modulo one turn.
  always_ff @(posedge clk_i) begin
    if (y_i[svpwm_pkg::CORDIC_W-1]) begin
      x_o <= x_i - (y_i >>> STEP);
      y_o <= y_i + (x_i >>> STEP);
      z_o <= z_i - ATAN;
    end else begin
      x_o <= x_i + (y_i >>> STEP);
      y_o <= y_i - (x_i >>> STEP);
      z_o <= z_i + ATAN;
    end
  end

endmodule

>>> rtl/svpwm_rot_cell.sv
// One step of the rotation CORDIC that produces the sine of a sector angle.
module svpwm_rot_cell #(
  parameter int STEP = 0
) (
  input  logic                                    clk_i,
  input  logic signed [svpwm_pkg::CORDIC_W-1:0]   x_i,
  input  logic signed [svpwm_pkg::CORDIC_W-1:0]   y_i,
  input  logic signed [svpwm_pkg::CORDIC_W-1:0]   z_i,
  output logic signed [svpwm_pkg::CORDIC_W-1:0]   x_o,
  output logic signed [svpwm_pkg::CORDIC_W-1:0]   y_o,
  output logic signed [svpwm_pkg::CORDIC_W-1:0]   z_o
);

  localparam logic signed [svpwm_pkg::CORDIC_W-1:0] ATAN =
    $signed({2'b00, svpwm_pkg::atan_turn(STEP)});

  // Rotate by the sign of the residual angle.
  always_ff @(posedge clk_i) begin
    if (!z_i[svpwm_pkg::CORDIC_W-1]) begin
      x_o <= x_i - (y_i >>> STEP);
      y_o <= y_i + (x_i >>> STEP);
      z_o <= z_i - ATAN;
    end else begin
      x_o <= x_i + (y_i >>> STEP);
      y_o <= y_i - (x_i >>> STEP);
      z_o <= z_i + ATAN;
    end
  end

endmodule

>>> rtl/svpwm_sqrt_cell.sv
// One digit of the exact square root: consumes two radicand bits, yields one root bit.
module svpwm_sqrt_cell (
  input  logic                                 clk_i,
  input  logic [svpwm_pkg::SQ_RAD_W-1:0]       rad_i,
  input  logic [svpwm_pkg::SQ_REM_W-1:0]       rem_i,
  input  logic [svpwm_pkg::SQ_ROOT_W-1:0]      root_i,
  output logic [svpwm_pkg::SQ_RAD_W-1:0]       rad_o,
  output logic [svpwm_pkg::SQ_REM_W-1:0]       rem_o,
  output logic [svpwm_pkg::SQ_ROOT_W-1:0]      root_o
);

  localparam int RW = svpwm_pkg::SQ_REM_W;
  localparam int QW = svpwm_pkg::SQ_ROOT_W;
  localparam int DW = svpwm_pkg::SQ_RAD_W;

  logic [RW+1:0] trial;
  logic [RW+1:0] cand;
  logic          fits;

  // Bring down the next digit pair and try 4*root+1.
  always_comb begin
    trial = {rem_i, rad_i[DW-1 -: 2]};
    cand  = {(RW-QW)'(0), root_i, 2'b01};
    fits  = trial >= cand;
  end

  always_ff @(posedge clk_i) begin
    rad_o  <= {rad_i[DW-3:0], 2'b00};
    rem_o  <= fits ? RW'(trial - cand) : trial[RW-1:0];
    root_o <= {root_i[QW-2:0], fits};
  end

endmodule

>>> rtl/svpwm_div_cell.sv
// One bit of the restoring division of the magnitude by the supply voltage.
module svpwm_div_cell (
  input  logic                                 clk_i,
  input  logic [svpwm_pkg::DIV_REM_W-1:0]      divisor_i,
  input  logic [svpwm_pkg::DIV_REM_W-1:0]      rem_i,
  input  logic [svpwm_pkg::DIV_NUM_W-1:0]      num_i,
  input  logic [svpwm_pkg::DIV_NUM_W-1:0]      quo_i,
  output logic [svpwm_pkg::DIV_REM_W-1:0]      rem_o,
  output logic [svpwm_pkg::DIV_NUM_W-1:0]      num_o,
  output logic [svpwm_pkg::DIV_NUM_W-1:0]      quo_o
);

  localparam int RW = svpwm_pkg::DIV_REM_W;
  localparam int NW = svpwm_pkg::DIV_NUM_W;

  logic [RW:0] trial;
  logic        fits;

  // Shift in the next dividend bit and subtract when the divisor fits.
  always_comb begin
    trial = {rem_i, num_i[NW-1]};
    fits  = trial >= {1'b0, divisor_i};
  end

  always_ff @(posedge clk_i) begin
    rem_o <= fits ? RW'(trial - {1'b0, divisor_i}) : trial[RW-1:0];
    num_o <= {num_i[NW-2:0], 1'b0};
    quo_o <= {quo_i[NW-2:0], fits};
  end

endmodule

>>> rtl/svpwm_chk.sv
// Port-level checker for the space-vector PWM duty block, bound to the top level.
module svpwm_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input svpwm_pkg::cmd_t                    cmd_i,
  input logic                               cfg_we_i,
  input logic [svpwm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input logic [svpwm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input logic                               done_o,
  input svpwm_pkg::res_t                    result_o
);

  localparam int LAT = svpwm_pkg::LATENCY;

  // Shadow of the period register, taken from the configuration port.
  logic [15:0] per_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_q <= svpwm_pkg::PERIOD_RESET;
    end else if (cfg_we_i && (cfg_idx_i == svpwm_pkg::CFG_PERIOD)) begin
      per_q <= cfg_wdata_i;
    end
  end

  // Every accepted word yields a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("accepted word produced no result");

  // No result without a word accepted the fixed latency earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result strobe without a matching word");

  // The raw sector is one to six.
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.raw_sector >= 3'd1) && (result_o.raw_sector <= 3'd6))
    else $error("raw sector out of range");

  // Compare values never exceed the programmed period.
  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.compare_a <= per_q) && (result_o.compare_b <= per_q)
               && (result_o.compare_c <= per_q))
    else $error("compare value above period");

  logic unused_cmd;
  assign unused_cmd = ^cmd_i;

endmodule

bind space_vector_pwm_duty svpwm_chk u_svpwm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .cmd_i       (cmd_i),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_wdata_i (cfg_wdata_i),
  .done_o      (done_o),
  .result_o    (result_o)
);
